// File: src/flow_sensor_frame_decoder_macros.svh
// ----------------------------------------------------------------------------
// flow sensor frame decoder assertion macros
// shared concurrent assertion forms, sampled on clk with rst_n low as disable
// ----------------------------------------------------------------------------
`ifndef FLOW_SENSOR_FRAME_DECODER_MACROS_SVH
`define FLOW_SENSOR_FRAME_DECODER_MACROS_SVH

// same-cycle implication
`define FSFD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSFD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/fsfd_pkg.sv
// ----------------------------------------------------------------------------
// fsfd_pkg
// types and constants shared by the flow sensor frame decoder modules
// ----------------------------------------------------------------------------
`default_nettype none

package fsfd_pkg;

    localparam int ERROR_LIMIT = 20;
    localparam int FRAME_BYTES = 6;
    localparam int FLOW_GAIN   = 1000;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // config port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_FLOW_SCALE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FLOW_OFFSET = 2'd1;

    // stream widths
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 160;
    localparam int OUT_USER_W = 2;

    // divider: |num| <= 65535 * 1000 < 2**26
    localparam int NUM_W     = 26;
    localparam int DIV_W     = 16;
    localparam int REM_W     = DIV_W + 1;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FLOW_CRC = 2'd1,
        STATUS_TEMP_CRC = 2'd2,
        STATUS_BUS_FAIL = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic calc;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic final_item;
        logic result_ok;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: src/fsfd_ctrl.sv
// ----------------------------------------------------------------------------
// fsfd_ctrl
// sequencer: byte intake, flow scaling multiply, serial divide, result load
// ----------------------------------------------------------------------------
`default_nettype none

module fsfd_ctrl
    import fsfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t dp_status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.accept   = 1'b0;
        cmd.calc     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = s_tvalid;
                if (s_tvalid && dp_status.final_item)
                begin
                    state_next = dp_status.result_ok ? ST_CALC : ST_FIN;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (dp_status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: src/fsfd_datapath.sv
// ----------------------------------------------------------------------------
// fsfd_datapath
// frame assembly, crc check, flow scaling and divide, counters, output word
// ----------------------------------------------------------------------------
`default_nettype none
`include "flow_sensor_frame_decoder_macros.svh"

module fsfd_datapath
    import fsfd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    input  wire logic [IN_USER_W-1:0]   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_DATA_W-1:0]       m_tdata,
    output logic [OUT_USER_W-1:0]       m_tuser,
    input  wire ctrl_cmd_t              cmd,
    output dp_status_t                  dp_status
);

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            x = x[7] ? ((x << 1) ^ CRC_POLY) : (x << 1);
        end
        return x;
    endfunction

    // config
    logic signed [15:0] scale_reg;
    logic signed [15:0] offset_reg;

    // frame state
    logic [2:0]   pos_reg, pos_next;
    logic [7:0]   crc_reg, crc_next;
    logic [7:0]   hold_reg, hold_next;
    logic [15:0]  flow_word_reg, flow_word_next;
    logic [15:0]  temp_word_reg, temp_word_next;
    logic         flow_ok_reg, flow_ok_next;
    status_t      status_reg, status_next;

    // divider
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic             neg_reg, neg_next;

    // counters
    logic [7:0]   run_reg, run_next;
    logic [7:0]   max_reg, max_next;
    logic [31:0]  fail_reg, fail_next;
    logic [31:0]  reinit_reg, reinit_next;
    logic [31:0]  attempt_reg, attempt_next;

    // output word
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [26:0]       out_flow_reg, out_flow_next;
    logic [14:0]       out_temp_reg, out_temp_next;
    logic              out_req_reg, out_req_next;

    logic [2:0]         pos;
    logic [7:0]         crc_in;
    status_t            frame_status;
    logic signed [16:0] diff;
    logic signed [26:0] prod;
    logic [26:0]        prod_mag;
    logic signed [15:0] scale_eff;
    logic [DIV_W-1:0]   scale_mag;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W:0]     trial;
    logic [26:0]        flow_val;
    logic signed [15:0] temp_s;
    logic signed [15:0] temp_half;
    logic [7:0]         run_inc;

    always_comb
    begin
        pos    = (pos_reg >= 3'(FRAME_BYTES)) ? 3'd0 : pos_reg;
        crc_in = crc_step(((pos == 3'd0) || (pos == 3'd3)) ? CRC_INIT : crc_reg, s_tdata);
        if (s_tuser[0])
            frame_status = STATUS_BUS_FAIL;
        else if (!flow_ok_reg)
            frame_status = STATUS_FLOW_CRC;
        else if (s_tdata != crc_reg)
            frame_status = STATUS_TEMP_CRC;
        else
            frame_status = STATUS_OK;
    end

    assign dp_status.final_item = s_tuser[0] || (pos == 3'(FRAME_BYTES - 1));
    assign dp_status.result_ok  = (frame_status == STATUS_OK);
    assign dp_status.out_free   = !out_valid_reg || m_tready;

    // scaling math
    always_comb
    begin
        diff      = $signed({flow_word_reg[15], flow_word_reg})
                  - $signed({offset_reg[15], offset_reg});
        prod      = $signed({{10{diff[16]}}, diff}) * $signed(27'(FLOW_GAIN));
        prod_mag  = prod[26] ? 27'(-prod) : 27'(prod);
        scale_eff = (scale_reg == 16'sd0) ? 16'sd1 : scale_reg;
        scale_mag = scale_eff[15] ? DIV_W'(-scale_eff) : DIV_W'(scale_eff);
        rem_sh    = {rem_reg[REM_W-2:0], quo_reg[NUM_W-1]};
        trial     = {1'b0, rem_sh} - {2'b00, dvs_reg};
        flow_val  = neg_reg ? 27'(-{1'b0, quo_reg}) : {1'b0, quo_reg};
        // raw * 100 / 200 is raw / 2 toward zero
        temp_s    = $signed(temp_word_reg);
        temp_half = (temp_s + $signed({15'd0, temp_s[15]})) >>> 1;
        run_inc   = run_reg + 8'd1;
    end

    always_comb
    begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        hold_next       = hold_reg;
        flow_word_next  = flow_word_reg;
        temp_word_next  = temp_word_reg;
        flow_ok_next    = flow_ok_reg;
        status_next     = status_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        neg_next        = neg_reg;
        run_next        = run_reg;
        max_next        = max_reg;
        fail_next       = fail_reg;
        reinit_next     = reinit_reg;
        attempt_next    = attempt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_flow_next   = out_flow_reg;
        out_temp_next   = out_temp_reg;
        out_req_next    = out_req_reg;

        if (cmd.accept)
        begin
            if (s_tuser[0])
            begin
                pos_next    = 3'd0;
                crc_next    = CRC_INIT;
                status_next = frame_status;
            end
            else
            begin
                unique case (pos)
                    3'd0, 3'd3:
                    begin
                        crc_next  = crc_in;
                        hold_next = s_tdata;
                        pos_next  = pos + 3'd1;
                    end
                    3'd1:
                    begin
                        crc_next       = crc_in;
                        flow_word_next = {hold_reg, s_tdata};
                        pos_next       = pos + 3'd1;
                    end
                    3'd2:
                    begin
                        flow_ok_next = (s_tdata == crc_reg);
                        crc_next     = CRC_INIT;
                        pos_next     = pos + 3'd1;
                    end
                    3'd4:
                    begin
                        crc_next       = crc_in;
                        temp_word_next = {hold_reg, s_tdata};
                        pos_next       = pos + 3'd1;
                    end
                    default:
                    begin
                        pos_next    = 3'd0;
                        crc_next    = CRC_INIT;
                        status_next = frame_status;
                    end
                endcase
            end
        end

        if (cmd.calc)
        begin
            quo_next = prod_mag[NUM_W-1:0];
            rem_next = '0;
            dvs_next = scale_mag;
            neg_next = prod[26] ^ scale_eff[15];
        end

        // restoring divide, one quotient bit per cycle
        if (cmd.div_step)
        begin
            if (!trial[REM_W])
            begin
                rem_next = trial[REM_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
        end

        if (cmd.load_out)
        begin
            out_valid_next  = 1'b1;
            out_status_next = status_reg;
            out_req_next    = 1'b0;
            attempt_next    = attempt_reg + 32'd1;
            if (status_reg == STATUS_OK)
            begin
                out_flow_next = flow_val;
                out_temp_next = temp_half[14:0];
                run_next      = 8'd0;
            end
            else
            begin
                out_flow_next = '0;
                out_temp_next = '0;
                fail_next     = fail_reg + 32'd1;
                run_next      = run_inc;
                if (run_inc > 8'(ERROR_LIMIT))
                begin
                    out_req_next = 1'b1;
                    run_next     = 8'd0;
                    reinit_next  = reinit_reg + 32'd1;
                end
                if (run_next > max_reg)
                begin
                    max_next = run_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= 16'sd1;
            offset_reg    <= 16'sd0;
            pos_reg       <= 3'd0;
            crc_reg       <= CRC_INIT;
            hold_reg      <= '0;
            flow_word_reg <= '0;
            temp_word_reg <= '0;
            flow_ok_reg   <= 1'b0;
            run_reg       <= '0;
            max_reg       <= '0;
            fail_reg      <= '0;
            reinit_reg    <= '0;
            attempt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_FLOW_SCALE))
                scale_reg <= $signed(cfg_data);
            if (cfg_we && (cfg_index == REG_FLOW_OFFSET))
                offset_reg <= $signed(cfg_data);
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            hold_reg      <= hold_next;
            flow_word_reg <= flow_word_next;
            temp_word_reg <= temp_word_next;
            flow_ok_reg   <= flow_ok_next;
            run_reg       <= run_next;
            max_reg       <= max_next;
            fail_reg      <= fail_next;
            reinit_reg    <= reinit_next;
            attempt_reg   <= attempt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        dvs_reg        <= dvs_next;
        neg_reg        <= neg_next;
        out_status_reg <= out_status_next;
        out_flow_reg   <= out_flow_next;
        out_temp_reg   <= out_temp_next;
        out_req_reg    <= out_req_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {5'd0, attempt_reg, reinit_reg, fail_reg, max_reg, run_reg,
                       out_req_reg, out_temp_reg, out_flow_reg};

    `FSFD_ASSERT_IMP(a_load_no_overwrite, cmd.load_out, !out_valid_reg || m_tready,
        "result loaded over a pending word")
    `FSFD_ASSERT_NXT(a_load_sets_valid, cmd.load_out, out_valid_reg,
        "loaded result not presented")
    `FSFD_ASSERT_IMP(a_error_zero_fields,
        out_valid_reg && (out_status_reg != STATUS_OK),
        (out_flow_reg == '0) && (out_temp_reg == '0),
        "error result carries nonzero values")
    `FSFD_ASSERT_IMP(a_req_clears_run, out_valid_reg && out_req_reg, run_reg == 8'd0,
        "reset request without cleared run")

endmodule

`default_nettype wire

// File: src/flow_sensor_frame_decoder.sv
// ----------------------------------------------------------------------------
// flow_sensor_frame_decoder
// decodes six-byte sensor reads into scaled flow and temperature with stats
// ----------------------------------------------------------------------------
// input stream: one word per received byte (tuser = 0) or a bus failure event
//   (tuser = 1). a read is flow hi, flow lo, crc, temp hi, temp lo, crc.
// output stream: one word per finished read or bus failure, with the status
//   code on tuser and the scaled values plus error statistics on tdata.
// config port: cfg_we writes register cfg_index (0 flow scale, 1 flow offset)
//   from cfg_data; other indexes are dropped. write only while idle.
// bytes that do not finish a read are taken back to back, with no wait state.
// a good read goes through a multiply by 1000, a restoring divide by the scale
//   and a load step before its word is registered at the output; errors and
//   bus failures skip the multiply and divide and go straight to the load step.
// the divide loop sets the pace: no new byte is taken while a result is in
//   the multiply, divide or load steps, so the bytes of a read cannot overlap
//   the arithmetic of the read before it.
// a finished word sits in the output register until taken; bytes keep flowing
//   in meanwhile, and a following result waits in the load step if the
//   receiver still stalls.
// reset clears the frame position, the crc seed, the error counters and the
//   output valid, and loads scale 1 and offset 0.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_sensor_frame_decoder
    import fsfd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // config write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // byte stream in
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  wire logic [IN_USER_W-1:0]   s_tuser,   // [0] cmd
    // result stream out
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [26:0] flow_ml_per_min, [41:27] temp_centi, [42] reset_request,
    // [50:43] error_run, [58:51] max_error_run, [90:59] error_total,
    // [122:91] reset_total, [154:123] read_total, [159:155] zero
    output logic [OUT_DATA_W-1:0]       m_tdata,
    output logic [OUT_USER_W-1:0]       m_tuser    // [1:0] status
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // sequencer
    fsfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // frame decode, arithmetic and output register
    fsfd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .dp_status (dp_status)
    );

endmodule

`default_nettype wire

// File: sim/tb_flow_sensor_frame_decoder.sv
// ----------------------------------------------------------------------------
// tb_flow_sensor_frame_decoder
// self-checking bench for the flow sensor frame decoder: a queue-fed byte
// driver and a result monitor with random gaps on both sides, checked
// against a cycle-free model of the read decode, crc checks and error stats
// ----------------------------------------------------------------------------
module tb_flow_sensor_frame_decoder
    import fsfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic CMD_BYTE     = 1'b0;
    localparam logic CMD_BUS_FAIL = 1'b1;

    // slowest read: multiply, divide and load plus the output hop
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_WORDS  = 110;

    // one byte word waiting to go onto the input stream
    typedef struct {
        logic       cmd;
        logic [7:0] data;
    } byte_word_t;

    // one decoded read as the block should report it
    typedef struct {
        status_t            status;
        logic signed [26:0] flow;
        logic signed [14:0] temp;
        logic               reinit_req;
        logic [7:0]         run;
        logic [7:0]         run_max;
        logic [31:0]        fails;
        logic [31:0]        reinits;
        logic [31:0]        attempts;
    } read_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic [IN_USER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [OUT_USER_W-1:0]  m_tuser;

    byte_word_t   byte_backlog[$];
    read_result_t predicted_reads[$];

    // model copy of the registers and the decoder state
    logic signed [15:0] cfg_scale;
    logic signed [15:0] cfg_offset;
    logic [2:0]         frame_pos;
    logic [7:0]         crc_acc;
    logic [7:0]         hi_hold;
    logic [15:0]        flow_raw;
    logic [15:0]        temp_raw;
    logic               flow_crc_good;
    logic [7:0]         err_run;
    logic [7:0]         err_run_peak;
    logic [31:0]        fail_tally;
    logic [31:0]        reinit_tally;
    logic [31:0]        attempt_tally;

    // stimulus side bookkeeping
    int unsigned  in_gap;
    int unsigned  out_stall;
    bit           in_gaps_on;
    bit           out_stalls_on;
    int unsigned  phase_words;
    int unsigned  mismatch_count;
    int unsigned  cycle_count;
    byte_word_t   next_word;
    read_result_t want;

    flow_sensor_frame_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] data_byte
        .s_tuser   (s_tuser),   // [0] cmd
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [26:0] flow, [41:27] temp, [42] reset_request,
                                // [50:43] error_run, [58:51] max_error_run,
                                // [90:59] error_total, [122:91] reset_total,
                                // [154:123] read_total
        .m_tuser   (m_tuser)    // [1:0] status
    );

    always #1 clk = ~clk;

    // crc-8, poly 0x31, msb first, one byte at a time
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc ^ b;
        for (int i = 0; i < 8; i++)
            x = x[7] ? ((x << 1) ^ CRC_POLY) : (x << 1);
        return x;
    endfunction

    // gap lengths: mostly none or short, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // raw sensor word, biased toward the signed extremes and toward zero and all ones
    function automatic logic [15:0] pick_word();
        if ($urandom_range(0, 99) < 12)
        begin
            case ($urandom_range(0, 3))
                0: return 16'h7FFF;
                1: return 16'h8000;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom);
    endfunction

    // advance the model by one accepted word, queue a result when a read ends
    task automatic decode_word(input logic cmd, input logic [7:0] b);
        read_result_t res;
        bit           done;
        longint       num;
        longint       divisor;
        longint       q;
        done = 0;
        res.status = STATUS_OK;
        res.flow = '0;
        res.temp = '0;
        res.reinit_req = 1'b0;
        if (frame_pos >= FRAME_BYTES)
            frame_pos = 0;
        if (cmd == CMD_BUS_FAIL)
        begin
            // bus failure drops any partial read and reseeds the crc
            frame_pos = 0;
            crc_acc = CRC_INIT;
            res.status = STATUS_BUS_FAIL;
            done = 1;
        end
        else
        begin
            case (frame_pos)
                3'd0, 3'd3:
                begin
                    crc_acc = crc8_next(CRC_INIT, b);
                    hi_hold = b;
                    frame_pos++;
                end
                3'd1:
                begin
                    crc_acc = crc8_next(crc_acc, b);
                    flow_raw = {hi_hold, b};
                    frame_pos++;
                end
                3'd2:
                begin
                    flow_crc_good = (b == crc_acc);
                    crc_acc = CRC_INIT;
                    frame_pos++;
                end
                3'd4:
                begin
                    crc_acc = crc8_next(crc_acc, b);
                    temp_raw = {hi_hold, b};
                    frame_pos++;
                end
                default:
                begin
                    frame_pos = 0;
                    done = 1;
                    // a bad flow crc wins over a bad temperature crc
                    if (!flow_crc_good)
                        res.status = STATUS_FLOW_CRC;
                    else if (b != crc_acc)
                        res.status = STATUS_TEMP_CRC;
                    else
                    begin
                        // zero scale divides as one, both divides truncate
                        divisor = (cfg_scale == 0) ? 1 : longint'(cfg_scale);
                        num = (longint'($signed(flow_raw)) - longint'(cfg_offset)) * FLOW_GAIN;
                        q = num / divisor;
                        res.flow = q[26:0];
                        q = (longint'($signed(temp_raw)) * 100) / 200;
                        res.temp = q[14:0];
                    end
                    crc_acc = CRC_INIT;
                end
            endcase
        end
        if (!done)
            return;
        if (res.status != STATUS_OK)
        begin
            res.flow = '0;
            res.temp = '0;
            err_run = err_run + 8'd1;
            fail_tally++;
            // run past the limit: ask for a sensor re-init and start over
            if (err_run > ERROR_LIMIT)
            begin
                res.reinit_req = 1'b1;
                err_run = '0;
                reinit_tally++;
            end
            if (err_run > err_run_peak)
                err_run_peak = err_run;
        end
        else
            err_run = '0;
        attempt_tally++;
        res.run = err_run;
        res.run_max = err_run_peak;
        res.fails = fail_tally;
        res.reinits = reinit_tally;
        res.attempts = attempt_tally;
        predicted_reads.push_back(res);
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    task automatic push_byte(input logic cmd, input logic [7:0] b);
        byte_word_t w;
        w.cmd = cmd;
        w.data = b;
        byte_backlog.push_back(w);
        phase_words++;
    endtask

    // a full six-byte read, optionally with a corrupted crc byte on either word
    task automatic push_read(input logic [15:0] flow_w, input logic [15:0] temp_w,
                             input bit spoil_flow, input bit spoil_temp);
        logic [7:0] fc;
        logic [7:0] tc;
        fc = crc8_next(crc8_next(CRC_INIT, flow_w[15:8]), flow_w[7:0]);
        tc = crc8_next(crc8_next(CRC_INIT, temp_w[15:8]), temp_w[7:0]);
        if (spoil_flow)
            fc ^= 8'($urandom_range(1, 255));
        if (spoil_temp)
            tc ^= 8'($urandom_range(1, 255));
        push_byte(CMD_BYTE, flow_w[15:8]);
        push_byte(CMD_BYTE, flow_w[7:0]);
        push_byte(CMD_BYTE, fc);
        push_byte(CMD_BYTE, temp_w[15:8]);
        push_byte(CMD_BYTE, temp_w[7:0]);
        push_byte(CMD_BYTE, tc);
    endtask

    // register write, only called while the decoder is idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_FLOW_SCALE)
            cfg_scale = val;
        else if (idx == REG_FLOW_OFFSET)
            cfg_offset = val;
    endtask

    // wait for every queued byte to be taken and every read to come back,
    // then give the divider time to finish anything still in flight
    task automatic wait_drained();
        while (byte_backlog.size() != 0 || s_tvalid || predicted_reads.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // byte driver: checks acceptance, then loads the next word after an
    // optional gap; valid is assigned once per edge so it never glitches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            in_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_word(s_tuser[0], s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (in_gap != 0)
                begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (byte_backlog.size() != 0)
                begin
                    next_word = byte_backlog.pop_front();
                    s_tuser  <= next_word.cmd;
                    s_tdata  <= next_word.data;
                    s_tvalid <= 1'b1;
                    if (in_gaps_on)
                        in_gap = pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor: compares each taken word with the oldest predicted
    // read, and stalls tready at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_reads.size() == 0)
                begin
                    $error("result word with no read pending");
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_reads.pop_front();
                    check_field("status", want.status, m_tuser[1:0]);
                    check_field("flow_ml_per_min", want.flow, $signed(m_tdata[26:0]));
                    check_field("temp_centi", want.temp, $signed(m_tdata[41:27]));
                    check_field("reset_request", want.reinit_req, m_tdata[42]);
                    check_field("error_run", want.run, m_tdata[50:43]);
                    check_field("max_error_run", want.run_max, m_tdata[58:51]);
                    check_field("error_total", want.fails, m_tdata[90:59]);
                    check_field("reset_total", want.reinits, m_tdata[122:91]);
                    check_field("read_total", want.attempts, m_tdata[154:123]);
                end
            end
            if (out_stall != 0)
            begin
                out_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (out_stalls_on && $urandom_range(0, 3) == 0)
                    out_stall = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] scale_set[7];
        logic [15:0] offset_set[7];
        int unsigned r;
        int unsigned k;

        scale_set  = '{16'h0001, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0003, 16'h0000};
        offset_set = '{16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h0000};
        scale_set[6]  = 16'($urandom);
        offset_set[6] = 16'($urandom);

        // model state as it comes out of reset
        cfg_scale = 16'sd1;
        cfg_offset = 16'sd0;
        frame_pos = '0;
        crc_acc = CRC_INIT;
        hi_hold = '0;
        flow_raw = '0;
        temp_raw = '0;
        flow_crc_good = 1'b0;
        err_run = '0;
        err_run_peak = '0;
        fail_tally = '0;
        reinit_tally = '0;
        attempt_tally = '0;
        mismatch_count = 0;
        cycle_count = 0;
        in_gaps_on = 1;
        out_stalls_on = 1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed reads at the reset register values
        write_reg(REG_FLOW_SCALE, 16'h0001);
        write_reg(REG_FLOW_OFFSET, 16'h0000);
        @(negedge clk);
        push_read(16'h7FFF, 16'h7FFF, 0, 0);    // largest positive words
        push_read(16'h8000, 16'h8000, 0, 0);    // most negative words
        push_read(16'h1234, 16'hFFFF, 1, 1);    // both crcs bad, flow reported
        push_read(16'hFFFF, 16'h0001, 0, 1);    // temperature crc bad only
        push_byte(CMD_BYTE, 8'h00);             // partial read cut by a bus failure
        push_byte(CMD_BYTE, 8'hFF);
        push_byte(CMD_BUS_FAIL, 8'hFF);         // data ignored on a failure
        wait_drained();

        // random phases, each under its own register setting
        for (int p = 0; p < 7; p++)
        begin
            write_reg(REG_FLOW_SCALE, scale_set[p]);
            write_reg(REG_FLOW_OFFSET, offset_set[p]);
            if (p % 2 == 1)
            begin
                write_reg(REG_SPARE_A, 16'($urandom));
                write_reg(REG_SPARE_B, 16'($urandom));
            end
            @(negedge clk);
            in_gaps_on = (p % 3 != 2);
            out_stalls_on = (p % 4 != 3);
            phase_words = 0;

            // a long failure run early on so the re-init request is hit
            if (p == 2)
                repeat (ERROR_LIMIT + 2) push_byte(CMD_BUS_FAIL, 8'($urandom));

            while (phase_words < PHASE_WORDS)
            begin
                r = $urandom_range(0, 99);
                if (r < 68)
                    push_read(pick_word(), pick_word(), 0, 0);
                else if (r < 76)
                    push_read(pick_word(), pick_word(), 1, $urandom_range(0, 1));
                else if (r < 84)
                    push_read(pick_word(), pick_word(), 0, 1);
                else if (r < 92)
                begin
                    // read broken off after a few bytes
                    k = $urandom_range(1, 5);
                    repeat (k) push_byte(CMD_BYTE, 8'($urandom));
                    push_byte(CMD_BUS_FAIL, 8'($urandom));
                end
                else if (r < 97)
                    push_byte(CMD_BUS_FAIL, 8'($urandom));
                else
                begin
                    // error run around the limit, mixing bad reads and failures
                    k = $urandom_range(ERROR_LIMIT - 2, ERROR_LIMIT + 3);
                    repeat (k)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            push_byte(CMD_BUS_FAIL, 8'($urandom));
                        else
                            push_read(pick_word(), pick_word(), $urandom_range(0, 1), 1);
                    end
                end
            end
            wait_drained();
        end

        if (mismatch_count == 0 && predicted_reads.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: flow_sensor_frame_decoder.f
+incdir+src
src/fsfd_pkg.sv
src/fsfd_ctrl.sv
src/fsfd_datapath.sv
src/flow_sensor_frame_decoder.sv
sim/tb_flow_sensor_frame_decoder.sv
